[design/crrs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crrs_pkg: shared types and constants
// Field structs, register indexes and sizes for the chunked read scheduler.
// ----------------------------------------------------------------------------
package crrs_pkg;
	localparam int READ_SLOTS  = 4;
	localparam int CHUNK_SLOTS = 16;
	localparam int ADDR_BITS   = 48;
	localparam int MAX_OUT     = 17;
	localparam int RS_W = $clog2(READ_SLOTS);
	localparam int CS_W = $clog2(CHUNK_SLOTS);
	localparam int CNT_W = $clog2(CHUNK_SLOTS + 1);
	localparam int OUT_CNT_W = $clog2(MAX_OUT + 1);

	localparam logic [2:0] REG_STORE_READY = 3'd0;
	localparam logic [2:0] REG_EXPERT_CNT  = 3'd1;
	localparam logic [2:0] REG_RECORDS_BASE = 3'd2;
	localparam logic [2:0] REG_STRIDE      = 3'd3;
	localparam logic [2:0] REG_CHUNK_SIZE  = 3'd4;
	localparam logic [2:0] REG_SLOTS_USED  = 3'd5;

	localparam logic [1:0] OP_REQUEST = 2'd0;
	localparam logic [1:0] OP_COMPLETE = 2'd1;
	localparam logic [1:0] OP_REMOVE  = 2'd2;
	localparam logic [1:0] OP_UNUSED  = 2'd3;

	localparam logic [1:0] KIND_ACCEPT = 2'd0;
	localparam logic [1:0] KIND_REJECT = 2'd1;
	localparam logic [1:0] KIND_ISSUE  = 2'd2;
	localparam logic [1:0] KIND_DONE   = 2'd3;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_INVALID = 3'd1;
	localparam logic [2:0] ST_NOSLOT  = 3'd2;
	localparam logic [2:0] ST_IOERR   = 3'd3;
	localparam logic [2:0] ST_REMOVED = 3'd4;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] expert_index;
		logic [47:0] buffer_base;
		logic [3:0]  chunk_slot;
		logic        success;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  read_slot;
		logic [3:0]  issue_slot;
		logic [47:0] device_address;
		logic [47:0] memory_address;
		logic [24:0] chunk_length;
		logic [2:0]  status;
		logic [4:0]  outstanding_peak;
		logic [63:0] bytes_read_total;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic        store_ready;
		logic [15:0] expert_count;
		logic [47:0] records_base;
		logic [40:0] record_stride;
		logic [24:0] chunk_size;
		logic [4:0]  chunk_slots_used;
	} cfg_t;
endpackage
`default_nettype wire

[design/chunked_read_request_scheduler.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chunked_read_request_scheduler: chunked read request scheduler
// Accepts read requests into read slots, cuts records into chunks and
// hands them to chunk slots, tracks completions and reports finished reads.
// ----------------------------------------------------------------------------
// Channel   Direction  Signals
// in        input      in_valid, in_stall, in_data (in_item_t)
// out       output     out_valid, out_stall, out_data (out_item_t)
// cfg       input      cfg_we, cfg_index, cfg_data
//
// A request first runs the shift-add multiplier for the record address (in
// S_MUL), then the pump walks the read slots and, for each active one, the
// chunk slots, passing one result at a time through S_EMIT. Each result parks
// in a one-entry hold so the final one can carry last; a result that must
// move waits while out_stall holds the output register. in_stall is high for
// the whole event, so no new event is taken before the last one is through.
// Reset clears slot and chunk busy bits, counters and the removal flag.
// ----------------------------------------------------------------------------
module chunked_read_request_scheduler (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  crrs_pkg::in_item_t        in_data,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output crrs_pkg::out_item_t       out_data,
	input  wire logic                 cfg_we,
	input  wire logic [2:0]           cfg_index,
	input  wire logic [47:0]          cfg_data
);
	import crrs_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_MUL   = 7'b0000010,
		S_SLOT  = 7'b0000100,
		S_CHUNK = 7'b0001000,
		S_DONE  = 7'b0010000,
		S_EMIT  = 7'b0100000,
		S_FLUSH = 7'b1000000
	} state_t;

	cfg_t cfg;
	crrs_cfg_regs u_cfg (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .cfg(cfg)
	);

	logic        mul_start, mul_busy;
	logic [47:0] mul_prod;
	crrs_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .mul_a(in_data.expert_index),
		.mul_b(cfg.record_stride), .busy(mul_busy), .product(mul_prod)
	);

	state_t state_q, ret_q;
	logic [READ_SLOTS-1:0]  slot_active_q;
	logic [47:0] slot_dev_q  [READ_SLOTS];
	logic [47:0] slot_buf_q  [READ_SLOTS];
	logic [40:0] slot_off_q  [READ_SLOTS];
	logic [CNT_W-1:0] slot_pend_q [READ_SLOTS];
	logic [2:0]  slot_err_q  [READ_SLOTS];
	logic [CHUNK_SLOTS-1:0] chunk_busy_q;
	logic [RS_W-1:0]  chunk_owner_q [CHUNK_SLOTS];
	logic [24:0] chunk_len_q [CHUNK_SLOTS];
	logic [CNT_W-1:0] in_flight_q, peak_q;
	logic [63:0] bytes_q;
	logic        gone_q;
	logic [RS_W-1:0] t_q, new_slot_q;
	logic [CS_W-1:0] i_q;
	logic [OUT_CNT_W-1:0] n_q;
	logic [47:0] buf_q;
	logic        out_valid_q;
	out_item_t   out_q;
	out_item_t   res;
	out_item_t   res_full;
	out_item_t   hold_q;
	logic        hold_v_q;
	logic        out_free, out_load;
	out_item_t   out_next;
	logic        last_t, last_i;
	logic        done_ok;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign mul_start = (state_q == S_IDLE) && in_valid && (in_data.op == OP_REQUEST);

	// clamp config values
	logic [4:0]  used;
	logic [24:0] csz;
	always_comb begin
		used = cfg.chunk_slots_used;
		if (used == 5'd0) used = 5'd1;
		if (used > 5'(CHUNK_SLOTS)) used = 5'(CHUNK_SLOTS);
		csz = (cfg.chunk_size == 25'd0) ? 25'd1 : cfg.chunk_size;
	end

	// free read slot search
	logic              any_free;
	logic [RS_W-1:0]   free_slot;
	always_comb begin
		any_free  = 1'b0;
		free_slot = '0;
		for (int k = READ_SLOTS - 1; k >= 0; k--) begin
			if (!slot_active_q[k]) begin
				any_free  = 1'b1;
				free_slot = RS_W'(k);
			end
		end
	end

	// current slot view
	logic        cur_fin;
	logic [40:0] remain;
	logic [24:0] clen;
	logic [2:0]  cur_err;
	always_comb begin
		cur_err = slot_err_q[t_q];
		cur_fin = (slot_off_q[t_q] >= cfg.record_stride);
		remain  = cfg.record_stride - slot_off_q[t_q];
		clen    = (remain > {16'd0, csz}) ? csz : remain[24:0];
	end

	assign last_t = (32'(t_q) == READ_SLOTS - 1);
	assign last_i = ({1'b0, i_q} + 5'd1 >= used) || (32'(i_q) == CHUNK_SLOTS - 1);
	assign done_ok = (n_q != OUT_CNT_W'(MAX_OUT)) && (slot_pend_q[t_q] == '0)
		&& (cur_err != ST_OK || cur_fin);

	// stamp a new result with the running peak and byte total
	always_comb begin
		res_full = res;
		res_full.outstanding_peak = peak_q;
		res_full.bytes_read_total = bytes_q;
		res_full.last = 1'b0;
	end

	// advance the held result into the output register when it is free; the
	// one pushed while flushing is the final result of the event
	assign out_free = !out_valid_q || !out_stall;
	always_comb begin
		out_load = hold_v_q && out_free && (state_q == S_EMIT || state_q == S_FLUSH);
		out_next = hold_q;
		out_next.last = (state_q == S_FLUSH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
			out_q       <= out_next;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			ret_q         <= S_IDLE;
			slot_active_q <= '0;
			chunk_busy_q  <= '0;
			in_flight_q   <= '0;
			peak_q        <= '0;
			bytes_q       <= '0;
			gone_q        <= 1'b0;
			hold_v_q      <= 1'b0;
			t_q <= '0;
			i_q <= '0;
			n_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						n_q <= '0;
						t_q <= '0;
						i_q <= '0;
						unique case (in_data.op)
							OP_REQUEST: begin
								buf_q      <= in_data.buffer_base;
								new_slot_q <= free_slot;
								if (!cfg.store_ready || in_data.expert_index >= cfg.expert_count
										|| gone_q) begin
									res <= '{kind: KIND_REJECT, status: ST_INVALID, default: '0};
									state_q <= S_EMIT;
									ret_q   <= S_SLOT;
								end else if (!any_free) begin
									res <= '{kind: KIND_REJECT, status: ST_NOSLOT, default: '0};
									state_q <= S_EMIT;
									ret_q   <= S_SLOT;
								end else begin
									state_q <= S_MUL;
								end
							end
							OP_COMPLETE: begin
								if (chunk_busy_q[in_data.chunk_slot[CS_W-1:0]]) begin
									chunk_busy_q[in_data.chunk_slot[CS_W-1:0]] <= 1'b0;
									if (in_flight_q != '0) in_flight_q <= in_flight_q - 1'b1;
									if (in_data.success)
										bytes_q <= bytes_q +
											64'(chunk_len_q[in_data.chunk_slot[CS_W-1:0]]);
									else
										slot_err_q[chunk_owner_q[in_data.chunk_slot[CS_W-1:0]]]
											<= ST_IOERR;
									if (slot_pend_q[chunk_owner_q[in_data.chunk_slot[CS_W-1:0]]]
											!= '0)
										slot_pend_q[chunk_owner_q[in_data.chunk_slot[CS_W-1:0]]]
											<= slot_pend_q[chunk_owner_q[
												in_data.chunk_slot[CS_W-1:0]]] - 1'b1;
								end
								state_q <= S_SLOT;
							end
							OP_REMOVE: begin
								gone_q  <= 1'b1;
								state_q <= S_SLOT;
							end
							default: state_q <= S_SLOT;
						endcase
					end
				end
				S_MUL: begin
					if (!mul_busy && !mul_start) begin
						slot_active_q[new_slot_q] <= 1'b1;
						slot_dev_q[new_slot_q]  <= cfg.records_base + mul_prod;
						slot_buf_q[new_slot_q]  <= buf_q;
						slot_off_q[new_slot_q]  <= '0;
						slot_pend_q[new_slot_q] <= '0;
						slot_err_q[new_slot_q]  <= ST_OK;
						res <= '{kind: KIND_ACCEPT, read_slot: new_slot_q, default: '0};
						state_q <= S_EMIT;
						ret_q   <= S_SLOT;
					end
				end
				S_SLOT: begin
					// enter a slot: skip inactive, apply removal status
					i_q <= '0;
					if (!slot_active_q[t_q]) begin
						if (last_t) state_q <= S_FLUSH;
						else t_q <= t_q + 1'b1;
					end else begin
						if (gone_q) slot_err_q[t_q] <= ST_REMOVED;
						state_q <= S_CHUNK;
					end
				end
				S_CHUNK: begin
					if (n_q == OUT_CNT_W'(MAX_OUT) || cur_err != ST_OK || cur_fin) begin
						state_q <= S_DONE;
					end else if (chunk_busy_q[i_q]) begin
						if (last_i) state_q <= S_DONE;
						else i_q <= i_q + 1'b1;
					end else begin
						chunk_busy_q[i_q]  <= 1'b1;
						chunk_owner_q[i_q] <= t_q;
						chunk_len_q[i_q]   <= clen;
						slot_pend_q[t_q]   <= slot_pend_q[t_q] + 1'b1;
						in_flight_q        <= in_flight_q + 1'b1;
						if (in_flight_q + 1'b1 > peak_q) peak_q <= in_flight_q + 1'b1;
						res <= '{kind: KIND_ISSUE, read_slot: t_q, issue_slot: 4'(i_q),
							device_address: slot_dev_q[t_q] + 48'(slot_off_q[t_q]),
							memory_address: slot_buf_q[t_q] + 48'(slot_off_q[t_q]),
							chunk_length: clen, default: '0};
						slot_off_q[t_q] <= slot_off_q[t_q] + 41'(clen);
						state_q <= S_EMIT;
						ret_q   <= last_i ? S_DONE : S_CHUNK;
						if (!last_i) i_q <= i_q + 1'b1;
					end
				end
				S_DONE: begin
					if (done_ok) begin
						slot_active_q[t_q] <= 1'b0;
						res <= '{kind: KIND_DONE, read_slot: t_q, status: cur_err,
							default: '0};
						state_q <= S_EMIT;
						ret_q   <= last_t ? S_FLUSH : S_SLOT;
					end else begin
						state_q <= last_t ? S_FLUSH : S_SLOT;
					end
					if (!last_t) t_q <= t_q + 1'b1;
				end
				S_EMIT: begin
					// park the new result; the older one leaves first
					if (!hold_v_q || out_free) begin
						hold_q   <= res_full;
						hold_v_q <= 1'b1;
						n_q <= n_q + 1'b1;
						state_q <= ret_q;
					end
				end
				S_FLUSH: begin
					// hand over the final result of the event, marked last
					if (!hold_v_q || out_free) begin
						hold_v_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(out_q));
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q));
	a_flight_count: assert property (@(posedge clk) disable iff (!arst_n)
		int'(in_flight_q) == $countones(chunk_busy_q));
	a_peak_bound: assert property (@(posedge clk) disable iff (!arst_n)
		peak_q >= in_flight_q);
endmodule
`default_nettype wire

[design/crrs_cfg_regs.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crrs_cfg_regs: configuration register file
// Holds the six registers written through the plain write port.
// ----------------------------------------------------------------------------
module crrs_cfg_regs (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [47:0] cfg_data,
	output crrs_pkg::cfg_t   cfg
);
	import crrs_pkg::*;
	cfg_t cfg_q;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.store_ready      <= 1'b0;
			cfg_q.expert_count     <= 16'd1;
			cfg_q.records_base     <= '0;
			cfg_q.record_stride    <= 41'd1048576;
			cfg_q.chunk_size       <= 25'd131072;
			cfg_q.chunk_slots_used <= 5'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_STORE_READY:  cfg_q.store_ready      <= cfg_data[0];
				REG_EXPERT_CNT:   cfg_q.expert_count     <= cfg_data[15:0];
				REG_RECORDS_BASE: cfg_q.records_base     <= cfg_data;
				REG_STRIDE:       cfg_q.record_stride    <= cfg_data[40:0];
				REG_CHUNK_SIZE:   cfg_q.chunk_size       <= cfg_data[24:0];
				REG_SLOTS_USED:   cfg_q.chunk_slots_used <= cfg_data[4:0];
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

[design/crrs_mul.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crrs_mul: shift-add multiplier
// Forms expert_index * record_stride one bit a cycle.
// ----------------------------------------------------------------------------
module crrs_mul (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [15:0] mul_a,
	input  wire logic [40:0] mul_b,
	output logic             busy,
	output logic [47:0]      product
);
	logic [15:0] a_q;
	logic [47:0] b_q;
	logic [47:0] acc_q;
	logic [4:0]  cnt_q;

	assign busy    = (cnt_q != 5'd0);
	assign product = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 5'd16;
		end else if (busy) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= mul_a;
			b_q   <= {7'd0, mul_b};
			acc_q <= '0;
		end else if (busy) begin
			if (a_q[0]) acc_q <= acc_q + b_q;
			a_q <= {1'b0, a_q[15:1]};
			b_q <= {b_q[46:0], 1'b0};
		end
	end
endmodule
`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: chunked read request scheduler testbench
// Drives request, completion and removal events under several register
// settings, predicts every accept, reject, chunk issue and read-done result
// in a scoreboard class, and checks each result as it leaves the block.
// ----------------------------------------------------------------------------
module tb;
	import crrs_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 100;

	// Scoreboard: keeps a private copy of the scheduler state and the queue
	// of results that accepted events are owed.
	class read_schedule_model;
		cfg_t        regs;
		bit          active    [READ_SLOTS];
		bit [47:0]   dev_base  [READ_SLOTS];
		bit [47:0]   buf_base  [READ_SLOTS];
		bit [40:0]   next_off  [READ_SLOTS];
		int          pending   [READ_SLOTS];
		logic [2:0]  err       [READ_SLOTS];
		bit          busy      [CHUNK_SLOTS];
		int          owner     [CHUNK_SLOTS];
		bit [24:0]   clen      [CHUNK_SLOTS];
		int          in_flight;
		int          peak;
		bit [63:0]   bytes;
		bit          gone;
		out_item_t   expected[$];
		int          emitted;
		int          mismatches;
		int          checked;

		function new();
			regs.store_ready      = 1'b0;
			regs.expert_count     = 16'd1;
			regs.records_base     = '0;
			regs.record_stride    = 41'd1048576;
			regs.chunk_size       = 25'd131072;
			regs.chunk_slots_used = 5'd1;
			foreach (active[t]) begin
				active[t] = 0;
				pending[t] = 0;
				err[t] = ST_OK;
			end
			foreach (busy[i]) busy[i] = 0;
			in_flight = 0;
			peak = 0;
			bytes = '0;
			gone = 0;
			mismatches = 0;
			checked = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [47:0] v);
			case (idx)
				REG_STORE_READY:  regs.store_ready = v[0];
				REG_EXPERT_CNT:   regs.expert_count = v[15:0];
				REG_RECORDS_BASE: regs.records_base = v;
				REG_STRIDE:       regs.record_stride = v[40:0];
				REG_CHUNK_SIZE:   regs.chunk_size = v[24:0];
				REG_SLOTS_USED:   regs.chunk_slots_used = v[4:0];
				default: ;
			endcase
		endfunction

		function int first_busy();
			foreach (busy[i]) if (busy[i]) return i;
			return -1;
		endfunction

		function int random_busy();
			int picks[$];
			foreach (busy[i]) if (busy[i]) picks.push_back(i);
			if (picks.size() == 0) return -1;
			return picks[$urandom_range(0, picks.size() - 1)];
		endfunction

		function void push(logic [1:0] kind, int rs, int is, bit [47:0] dev, bit [47:0] mem,
				bit [24:0] len, logic [2:0] st);
			out_item_t r;
			r.kind = kind;
			r.read_slot = rs[1:0];
			r.issue_slot = is[3:0];
			r.device_address = dev;
			r.memory_address = mem;
			r.chunk_length = len;
			r.status = st;
			r.outstanding_peak = peak[4:0];
			r.bytes_read_total = bytes;
			r.last = 1'b0;
			expected.push_back(r);
			emitted++;
		endfunction

		// Serve active read slots in order, issuing chunks into free chunk slots.
		function void serve_slots();
			int used;
			bit [63:0] csz;
			bit [63:0] len;
			used = regs.chunk_slots_used;
			csz = (regs.chunk_size == 0) ? 64'd1 : 64'(regs.chunk_size);
			if (used < 1) used = 1;
			if (used > CHUNK_SLOTS) used = CHUNK_SLOTS;
			for (int t = 0; t < READ_SLOTS; t++) begin
				if (!active[t]) continue;
				if (gone) err[t] = ST_REMOVED;
				for (int i = 0; i < used && emitted < MAX_OUT; i++) begin
					if (err[t] != ST_OK || next_off[t] >= regs.record_stride) break;
					if (busy[i]) continue;
					len = 64'(regs.record_stride) - 64'(next_off[t]);
					if (len > csz) len = csz;
					busy[i] = 1;
					owner[i] = t;
					clen[i] = len[24:0];
					pending[t]++;
					in_flight++;
					if (in_flight > peak) peak = in_flight;
					push(KIND_ISSUE, t, i, 48'(64'(dev_base[t]) + 64'(next_off[t])),
						48'(64'(buf_base[t]) + 64'(next_off[t])), len[24:0], ST_OK);
					next_off[t] = 41'(64'(next_off[t]) + len);
				end
				if (emitted < MAX_OUT && pending[t] == 0 &&
						(err[t] != ST_OK || next_off[t] >= regs.record_stride)) begin
					active[t] = 0;
					push(KIND_DONE, t, 0, '0, '0, '0, err[t]);
				end
			end
		endfunction

		function void note_event(in_item_t x);
			int t;
			int cs;
			bit [63:0] addr;
			emitted = 0;
			case (x.op)
				OP_REQUEST: begin
					if (!regs.store_ready || x.expert_index >= regs.expert_count || gone) begin
						push(KIND_REJECT, 0, 0, '0, '0, '0, ST_INVALID);
					end else begin
						for (t = 0; t < READ_SLOTS; t++) if (!active[t]) break;
						if (t == READ_SLOTS) begin
							push(KIND_REJECT, 0, 0, '0, '0, '0, ST_NOSLOT);
						end else begin
							addr = 64'(regs.records_base) +
								64'(x.expert_index) * 64'(regs.record_stride);
							active[t] = 1;
							dev_base[t] = addr[47:0];
							buf_base[t] = x.buffer_base;
							next_off[t] = '0;
							pending[t] = 0;
							err[t] = ST_OK;
							push(KIND_ACCEPT, t, 0, '0, '0, '0, ST_OK);
						end
					end
				end
				OP_COMPLETE: begin
					cs = x.chunk_slot;
					if (busy[cs]) begin
						t = owner[cs];
						busy[cs] = 0;
						if (in_flight > 0) in_flight--;
						if (x.success) bytes += 64'(clen[cs]);
						else err[t] = ST_IOERR;
						if (pending[t] > 0) pending[t]--;
					end
				end
				OP_REMOVE: gone = 1;
				default: ;
			endcase
			serve_slots();
			if (emitted > 0) expected[expected.size() - 1].last = 1'b1;
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= 10) $display("[%0t] MISMATCH %s", $realtime, msg);
		endfunction

		function void check_result(out_item_t got);
			out_item_t e;
			string bad;
			checked++;
			if (expected.size() == 0) begin
				flag($sformatf("unexpected result %p", got));
				return;
			end
			e = expected.pop_front();
			bad = "";
			if (got.kind !== e.kind) bad = {bad, " kind"};
			if (got.read_slot !== e.read_slot) bad = {bad, " read_slot"};
			if (got.issue_slot !== e.issue_slot) bad = {bad, " issue_slot"};
			if (got.device_address !== e.device_address) bad = {bad, " device_address"};
			if (got.memory_address !== e.memory_address) bad = {bad, " memory_address"};
			if (got.chunk_length !== e.chunk_length) bad = {bad, " chunk_length"};
			if (got.status !== e.status) bad = {bad, " status"};
			if (got.outstanding_peak !== e.outstanding_peak) bad = {bad, " outstanding_peak"};
			if (got.bytes_read_total !== e.bytes_read_total) bad = {bad, " bytes_read_total"};
			if (got.last !== e.last) bad = {bad, " last"};
			if (bad != "")
				flag($sformatf("fields:%s\n  expected %p\n  actual   %p", bad, e, got));
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_data;
	logic      cfg_we;
	logic [2:0]  cfg_index;
	logic [47:0] cfg_data;

	read_schedule_model model = new();
	bit steady;   // sender offers back to back when set
	int idle_cycles;

	chunked_read_request_scheduler dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Offer one event transaction, after a random gap, and hold it until taken.
	// Acceptance is judged at the falling edge, where inputs and stall are stable.
	task automatic drive_event(in_item_t x);
		int gap;
		int r;
		bit taken;
		gap = 0;
		if (!steady) begin
			r = $urandom_range(0, 99);
			if (r >= 95) gap = $urandom_range(15, 50);
			else if (r >= 65) gap = $urandom_range(1, 4);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= x;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		model.note_event(x);
	endtask

	// Drop valid and wait until every owed result has come, then let the block
	// finish any event that produces no result.
	task automatic settle();
		in_valid <= 1'b0;
		while (model.expected.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_registers(cfg_t c);
		logic [2:0] idx [6];
		logic [47:0] v;
		idx = '{REG_STORE_READY, REG_EXPERT_CNT, REG_RECORDS_BASE,
			REG_STRIDE, REG_CHUNK_SIZE, REG_SLOTS_USED};
		for (int i = 0; i < 6; i++) begin
			case (idx[i])
				REG_STORE_READY:  v = 48'(c.store_ready);
				REG_EXPERT_CNT:   v = 48'(c.expert_count);
				REG_RECORDS_BASE: v = c.records_base;
				REG_STRIDE:       v = 48'(c.record_stride);
				REG_CHUNK_SIZE:   v = 48'(c.chunk_size);
				default:          v = 48'(c.chunk_slots_used);
			endcase
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= v;
			@(posedge clk);
			model.set_reg(idx[i], v);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic in_item_t make_event(logic [1:0] op, int expert, logic [47:0] buffer,
			int cslot, bit ok);
		in_item_t x;
		x.op = op;
		x.expert_index = expert[15:0];
		x.buffer_base = buffer;
		x.chunk_slot = cslot[3:0];
		x.success = ok;
		return x;
	endfunction

	function automatic logic [47:0] rand48();
		return {16'($urandom), 32'($urandom)};
	endfunction

	// Complete every chunk still in flight, all successfully.
	task automatic drain_chunks();
		int cs;
		cs = model.first_busy();
		while (cs >= 0) begin
			drive_event(make_event(OP_COMPLETE, $urandom, rand48(), cs, 1'b1));
			cs = model.first_busy();
		end
	endtask

	// Mostly well-formed traffic: requests for valid records and completions of
	// chunks really in flight; the rest is out-of-range requests, spurious
	// completions and the unused op code.
	task automatic send_random(int count);
		int r;
		int cs;
		int expert;
		logic [1:0] op;
		in_item_t x;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			cs = model.random_busy();
			if (r < 40) begin
				expert = ($urandom_range(0, 9) == 0) ? int'($urandom) :
					$urandom_range(0, model.regs.expert_count);
				x = make_event(OP_REQUEST, expert, rand48(), $urandom, 1'($urandom));
			end else if (r < 88 && cs >= 0) begin
				x = make_event(OP_COMPLETE, $urandom, rand48(), cs, $urandom_range(0, 19) != 0);
			end else if (r < 96) begin
				x = make_event(OP_COMPLETE, $urandom, rand48(), $urandom, 1'($urandom));
			end else begin
				op = OP_UNUSED;
				x = make_event(op, $urandom, rand48(), $urandom, 1'($urandom));
			end
			drive_event(x);
		end
	endtask

	function automatic cfg_t random_config();
		cfg_t c;
		c.store_ready = 1'b1;
		c.expert_count = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535)) :
			16'($urandom_range(1, 8));
		c.records_base = rand48();
		c.record_stride = 41'($urandom_range(1, 60000));
		c.chunk_size = 25'($urandom_range(4096, 32768));
		c.chunk_slots_used = 5'($urandom_range(0, 20));
		return c;
	endfunction

	// Receiver: random stalls in short and long bursts, quiet stretches with no
	// stall at all, and one long hold-off that backs the block up into its input.
	initial begin
		int burst;
		int r;
		bit quiet;
		bit held;
		out_stall = 1'b0;
		burst = 0;
		quiet = 0;
		held = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!held && model.checked >= 150) begin
				burst = 600;
				held = 1;
			end
			if (burst > 0) begin
				out_stall <= 1'b1;
				burst--;
			end else if (quiet) begin
				out_stall <= 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					out_stall <= 1'b0;
				end else begin
					out_stall <= 1'b1;
					burst = (r < 96) ? $urandom_range(0, 3) : $urandom_range(15, 50);
				end
			end
			if ($urandom_range(0, 299) == 0) quiet = !quiet;
			@(negedge clk);
			if (out_valid && !out_stall) model.check_result(out_data);
		end
	end

	// Watchdog: end the run if no transaction moves on either channel for too long.
	initial idle_cycles = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		cfg_t c;
		int cs;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		steady = 0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Store not ready: requests rejected; spurious completion and unused op.
		drive_event(make_event(OP_REQUEST, 0, '0, 0, 1'b0));
		drive_event(make_event(OP_COMPLETE, 0, '0, 0, 1'b1));
		drive_event(make_event(OP_UNUSED, 0, '0, 0, 1'b0));
		settle();

		// Base near the top of the address space, so device addresses wrap.
		c.store_ready = 1'b1;
		c.expert_count = 16'd4;
		c.records_base = 48'hFFFF_FFFF_F000;
		c.record_stride = 41'd10000;
		c.chunk_size = 25'd4096;
		c.chunk_slots_used = 5'd16;
		program_registers(c);
		drive_event(make_event(OP_REQUEST, 0, 48'hFFFF_FFFF_FFFF, 0, 1'b0));
		drive_event(make_event(OP_REQUEST, 3, '0, 0, 1'b0));
		drive_event(make_event(OP_REQUEST, 4, '0, 0, 1'b0));
		drive_event(make_event(OP_REQUEST, 65535, 48'hFFFF_FFFF_FFFF, 15, 1'b1));
		drive_event(make_event(OP_REQUEST, 1, 48'h0000_1234_5678, 0, 1'b0));
		drive_event(make_event(OP_REQUEST, 2, 48'h8000_0000_0000, 0, 1'b0));
		// all read slots taken: no free slot
		drive_event(make_event(OP_REQUEST, 1, '0, 0, 1'b0));
		// io error on one chunk stops its read
		cs = model.first_busy();
		drive_event(make_event(OP_COMPLETE, 0, '0, cs, 1'b0));
		drive_event(make_event(OP_UNUSED, 65535, 48'hFFFF_FFFF_FFFF, 15, 1'b1));
		drive_event(make_event(OP_COMPLETE, 0, '0, 15, 1'b1));
		drain_chunks();
		settle();

		// Record and chunk size at their top bit, largest base; slot count beyond range is clamped.
		c.expert_count = 16'hFFFF;
		c.records_base = 48'hFFFF_FFFF_FFFF;
		c.record_stride = 41'd1 << 40;
		c.chunk_size = 25'd1 << 24;
		c.chunk_slots_used = 5'd31;
		program_registers(c);
		send_random(30);
		settle();

		// Stride shrinks under reads that are still open: they count as finished.
		// Zero chunk size acts as one byte; zero slot count acts as one.
		c.expert_count = 16'd1;
		c.records_base = '0;
		c.record_stride = 41'd3;
		c.chunk_size = 25'd0;
		c.chunk_slots_used = 5'd0;
		program_registers(c);
		send_random(30);
		drain_chunks();
		settle();

		for (int p = 0; p < 6; p++) begin
			steady = (p == 2);
			program_registers(random_config());
			send_random(50);
			settle();
		end
		steady = 0;

		// Device removal: open reads end as removed, further requests rejected.
		program_registers(random_config());
		send_random(20);
		drive_event(make_event(OP_REMOVE, $urandom, rand48(), $urandom, 1'($urandom)));
		send_random(30);
		drain_chunks();
		settle();

		if (model.mismatches == 0 && model.expected.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule

[filelist.f]
design/crrs_pkg.sv
design/crrs_cfg_regs.sv
design/crrs_mul.sv
design/chunked_read_request_scheduler.sv
tb/sv/tb.sv
